### hdl/affine_point_transform_2d_macros.svh
// Assertion helpers, clocked on clk_i and disabled in reset.
`ifndef AFFINE_POINT_TRANSFORM_2D_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_2D_MACROS_SVH

// Same-cycle implication.
`define APT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define APT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### hdl/apt_pkg.sv
package apt_pkg;

  localparam int ACC_W = 64;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int unsigned TAYLOR_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  typedef enum logic [2:0] {
    CFG_ROT   = 3'd0,
    CFG_SX    = 3'd1,
    CFG_SY    = 3'd2,
    CFG_HX    = 3'd3,
    CFG_HY    = 3'd4,
    CFG_ORG   = 3'd5,
    CFG_TRANS = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    A_SIN, A_COS, A_TMP, A_COEF_A, A_COEF_B, A_COEF_D, A_COEF_E, A_AM1, A_EM1
  } a_sel_e;

  typedef enum logic [2:0] {
    B_SX, B_SY, B_HX, B_HY, B_OX, B_OY, B_X, B_Y
  } b_sel_e;

  typedef enum logic [1:0] {T_TX, T_TY, T_OC, T_OF} t_sel_e;

  typedef enum logic [2:0] {ACC_NONE, ACC_LOAD, ACC_LOADNEG, ACC_ADD, ACC_SUB} acc_op_e;

  typedef enum logic [1:0] {SRC_PROD, SRC_PROD8, SRC_TERM} src_e;

  typedef enum logic [2:0] {
    FIN_NONE, FIN_TMP, FIN_COEF, FIN_OFF, FIN_PX, FIN_PY, FIN_SIN, FIN_COS
  } fin_e;

  typedef enum logic [1:0] {ST_IDLE, ST_REBUILD, ST_POINT} state_e;

  typedef struct packed {
    a_sel_e     a_sel;
    b_sel_e     b_sel;
    t_sel_e     t_sel;
    acc_op_e    acc_op;
    src_e       src;
    fin_e       fin;
    logic [1:0] dst;
    logic       rom_cos;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic cfg_hit;
  } dp_status_t;

  localparam cmd_t CMD_NOP = '{a_sel: A_SIN, b_sel: B_SX, t_sel: T_TX, acc_op: ACC_NONE,
                               src: SRC_PROD, fin: FIN_NONE, dst: 2'd0, rom_cos: 1'b0};

  localparam logic [4:0] REBUILD_LAST = 5'd25;
  localparam logic [2:0] POINT_LAST   = 3'd7;

  function automatic cmd_t mk(input a_sel_e a, input b_sel_e b, input acc_op_e op,
                              input src_e src, input fin_e fin, input logic [1:0] dst);
    cmd_t c;
    c = CMD_NOP;
    c.a_sel  = a;
    c.b_sel  = b;
    c.acc_op = op;
    c.src    = src;
    c.fin    = fin;
    c.dst    = dst;
    return c;
  endfunction

  function automatic cmd_t mk_term(input t_sel_e t, input acc_op_e op);
    cmd_t c;
    c = CMD_NOP;
    c.t_sel  = t;
    c.acc_op = op;
    c.src    = SRC_TERM;
    return c;
  endfunction

  function automatic cmd_t rebuild_cmd(input logic [4:0] step);
    cmd_t c;
    c = CMD_NOP;
    case (step)
      5'd0:  c.fin = FIN_SIN;
      5'd1:  begin
        c.fin     = FIN_COS;
        c.rom_cos = 1'b1;
      end
      5'd2:  c = mk(A_SIN, B_HY, ACC_NONE, SRC_PROD, FIN_TMP, 2'd0);
      5'd3:  c = mk(A_COS, B_SX, ACC_LOAD, SRC_PROD8, FIN_NONE, 2'd0);
      5'd4:  c = mk(A_TMP, B_SY, ACC_SUB, SRC_PROD, FIN_NONE, 2'd0);
      5'd5:  c = mk(A_SIN, B_SX, ACC_NONE, SRC_PROD, FIN_COEF, 2'd0);
      5'd6:  c = mk(A_COS, B_HX, ACC_NONE, SRC_PROD, FIN_TMP, 2'd0);
      5'd7:  c = mk(A_SIN, B_SY, ACC_LOADNEG, SRC_PROD8, FIN_NONE, 2'd0);
      5'd8:  c = mk(A_TMP, B_SX, ACC_ADD, SRC_PROD, FIN_NONE, 2'd0);
      5'd9:  c = mk(A_SIN, B_SX, ACC_NONE, SRC_PROD, FIN_COEF, 2'd1);
      5'd10: c = mk(A_COS, B_HY, ACC_NONE, SRC_PROD, FIN_TMP, 2'd0);
      5'd11: c = mk(A_SIN, B_SX, ACC_LOAD, SRC_PROD8, FIN_NONE, 2'd0);
      5'd12: c = mk(A_TMP, B_SY, ACC_ADD, SRC_PROD, FIN_NONE, 2'd0);
      5'd13: c = mk(A_SIN, B_SX, ACC_NONE, SRC_PROD, FIN_COEF, 2'd2);
      5'd14: c = mk(A_SIN, B_HX, ACC_NONE, SRC_PROD, FIN_TMP, 2'd0);
      5'd15: c = mk(A_COS, B_SY, ACC_LOAD, SRC_PROD8, FIN_NONE, 2'd0);
      5'd16: c = mk(A_TMP, B_SX, ACC_ADD, SRC_PROD, FIN_NONE, 2'd0);
      5'd17: c = mk(A_SIN, B_SX, ACC_NONE, SRC_PROD, FIN_COEF, 2'd3);
      5'd18: c = mk(A_AM1, B_OX, ACC_LOADNEG, SRC_PROD, FIN_NONE, 2'd0);
      5'd19: c = mk(A_COEF_B, B_OY, ACC_SUB, SRC_PROD, FIN_NONE, 2'd0);
      5'd20: c = mk_term(T_TX, ACC_ADD);
      5'd21: c = mk(A_SIN, B_SX, ACC_NONE, SRC_PROD, FIN_OFF, 2'd0);
      5'd22: c = mk(A_COEF_D, B_OX, ACC_LOADNEG, SRC_PROD, FIN_NONE, 2'd0);
      5'd23: c = mk(A_EM1, B_OY, ACC_SUB, SRC_PROD, FIN_NONE, 2'd0);
      5'd24: c = mk_term(T_TY, ACC_ADD);
      5'd25: c = mk(A_SIN, B_SX, ACC_NONE, SRC_PROD, FIN_OFF, 2'd1);
      default: c = CMD_NOP;
    endcase
    return c;
  endfunction

  function automatic cmd_t point_cmd(input logic [2:0] step);
    cmd_t c;
    c = CMD_NOP;
    case (step)
      3'd0: c = mk_term(T_OC, ACC_LOAD);
      3'd1: c = mk(A_COEF_A, B_X, ACC_ADD, SRC_PROD, FIN_NONE, 2'd0);
      3'd2: c = mk(A_COEF_B, B_Y, ACC_ADD, SRC_PROD, FIN_NONE, 2'd0);
      3'd3: c = mk(A_SIN, B_SX, ACC_NONE, SRC_PROD, FIN_PX, 2'd0);
      3'd4: c = mk_term(T_OF, ACC_LOAD);
      3'd5: c = mk(A_COEF_D, B_X, ACC_ADD, SRC_PROD, FIN_NONE, 2'd0);
      3'd6: c = mk(A_COEF_E, B_Y, ACC_ADD, SRC_PROD, FIN_NONE, 2'd0);
      3'd7: c = mk(A_SIN, B_SX, ACC_NONE, SRC_PROD, FIN_PY, 2'd0);
      default: c = CMD_NOP;
    endcase
    return c;
  endfunction

endpackage

### hdl/apt_sine_rom.sv
module apt_sine_rom
  import apt_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COEF_FRAC_BITS   = 14
) (
  input  logic                           clk_i,
  input  logic [15:0]                    angle_i,
  output logic signed [COEF_FRAC_BITS+1:0] sine_o
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

  function automatic logic [63:0] quarter_sine(input int unsigned k);
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    one = 64'd1 << COEF_FRAC_BITS;
    if (k >= SINE_TABLE_DEPTH) return one;
    x    = (64'(k) * PI_Q30) / (2 * SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    sum = $signed((64'(sum) + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS));
    if (sum > $signed(one)) sum = $signed(one);
    return 64'(sum);
  endfunction

  logic [COEF_FRAC_BITS:0] tbl [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tbl
    assign tbl[k] = (COEF_FRAC_BITS + 1)'(quarter_sine(k));
  end

  logic [31:0]                     scaled;
  logic [IW-1:0]                   ix;
  logic [IW-1:0]                   idx;
  logic signed [COEF_FRAC_BITS+1:0] mag;

  assign scaled = 32'(angle_i[13:0]) * 32'(SINE_TABLE_DEPTH);
  assign ix     = IW'(scaled >> 14);
  assign idx    = angle_i[14] ? IW'(SINE_TABLE_DEPTH) - ix : ix;
  assign mag    = $signed({1'b0, tbl[idx]});

  always_ff @(posedge clk_i) begin
    sine_o <= angle_i[15] ? -mag : mag;
  end

endmodule

### hdl/apt_datapath.sv
module apt_datapath
  import apt_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COEF_FRAC_BITS   = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_wdata_i,
  input  logic               in_load_i,
  input  logic signed [23:0] in_x_i,
  input  logic signed [23:0] in_y_i,
  input  cmd_t               cmd_i,
  input  logic               out_ready_i,
  output dp_status_t         status_o,
  output logic               out_valid_o,
  output logic signed [23:0] out_x_o,
  output logic signed [23:0] out_y_o,
  output logic               out_sat_o
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int AW = (F + 18 > 33) ? F + 18 : 33;
  localparam int PW = AW + 24;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [24:0] sat24(input logic signed [ACC_W-1:0] v);
    if (v > 64'sd8388607) return {1'b1, 24'h7fffff};
    if (v < -64'sd8388608) return {1'b1, 24'h800000};
    return {1'b0, v[23:0]};
  endfunction

  logic [15:0]        rot_q;
  logic signed [15:0] sx_q, sy_q, hx_q, hy_q;
  logic [47:0]        org_q, trans_q;
  cmd_t               cmd_q;
  logic               out_valid_q;

  logic signed [F+1:0]       sin_q, cos_q, rom_q;
  logic signed [AW-1:0]      tmp_q;
  logic signed [31:0]        ca_q, cb_q, cd_q, ce_q, oc_q, of_q;
  logic signed [23:0]        x_q, y_q, rx_q;
  logic                      satx_q;
  logic signed [PW-1:0]      prod_q;
  logic signed [ACC_W-1:0]   term_q, acc_q;
  logic signed [23:0]        ox_w, oy_w, tx_w, ty_w;
  logic signed [23:0]        outx_q, outy_q;
  logic                      outsat_q;

  logic signed [AW-1:0]    a_op, one_w;
  logic signed [23:0]      b_op;
  logic signed [31:0]      t_op;
  logic signed [ACC_W-1:0] addend, acc_d, rnd16, rndf;
  logic [15:0]             rom_angle;
  logic                    hit;
  logic [24:0]             satv;

  assign ox_w  = $signed(org_q[23:0]);
  assign oy_w  = $signed(org_q[47:24]);
  assign tx_w  = $signed(trans_q[23:0]);
  assign ty_w  = $signed(trans_q[47:24]);
  assign one_w = AW'(1) <<< F;

  assign rom_angle = cmd_i.rom_cos ? rot_q + 16'h4000 : rot_q;

  apt_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .angle_i(rom_angle),
    .sine_o (rom_q)
  );

  always_comb begin
    hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROT, CFG_SX, CFG_SY, CFG_HX, CFG_HY, CFG_ORG, CFG_TRANS: hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.a_sel)
      A_SIN:    a_op = AW'(sin_q);
      A_COS:    a_op = AW'(cos_q);
      A_TMP:    a_op = tmp_q;
      A_COEF_A: a_op = AW'(ca_q);
      A_COEF_B: a_op = AW'(cb_q);
      A_COEF_D: a_op = AW'(cd_q);
      A_COEF_E: a_op = AW'(ce_q);
      A_AM1:    a_op = AW'(ca_q) - one_w;
      A_EM1:    a_op = AW'(ce_q) - one_w;
      default:  a_op = '0;
    endcase
    case (cmd_i.b_sel)
      B_SX:    b_op = 24'(sx_q);
      B_SY:    b_op = 24'(sy_q);
      B_HX:    b_op = 24'(hx_q);
      B_HY:    b_op = 24'(hy_q);
      B_OX:    b_op = ox_w;
      B_OY:    b_op = oy_w;
      B_X:     b_op = x_q;
      B_Y:     b_op = y_q;
      default: b_op = '0;
    endcase
    case (cmd_i.t_sel)
      T_TX:    t_op = 32'(tx_w);
      T_TY:    t_op = 32'(ty_w);
      T_OC:    t_op = oc_q;
      T_OF:    t_op = of_q;
      default: t_op = '0;
    endcase
  end

  always_comb begin
    case (cmd_q.src)
      SRC_PROD:  addend = ACC_W'(prod_q);
      SRC_PROD8: addend = ACC_W'(prod_q) <<< 8;
      SRC_TERM:  addend = term_q;
      default:   addend = '0;
    endcase
    case (cmd_q.acc_op)
      ACC_LOAD:    acc_d = addend;
      ACC_LOADNEG: acc_d = -addend;
      ACC_ADD:     acc_d = acc_q + addend;
      ACC_SUB:     acc_d = acc_q - addend;
      default:     acc_d = acc_q;
    endcase
  end

  assign rnd16 = (acc_q + 64'sd32768) >>> 16;
  assign rndf  = (acc_q + (64'sd1 <<< (F - 1))) >>> F;
  assign satv  = sat24(rndf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q       <= 16'd0;
      sx_q        <= 16'sd256;
      sy_q        <= 16'sd256;
      hx_q        <= 16'sd0;
      hy_q        <= 16'sd0;
      org_q       <= 48'd0;
      trans_q     <= 48'd0;
      cmd_q       <= CMD_NOP;
      out_valid_q <= 1'b0;
    end else begin
      cmd_q <= cmd_i;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROT:   rot_q   <= cfg_wdata_i[15:0];
          CFG_SX:    sx_q    <= $signed(cfg_wdata_i[15:0]);
          CFG_SY:    sy_q    <= $signed(cfg_wdata_i[15:0]);
          CFG_HX:    hx_q    <= $signed(cfg_wdata_i[15:0]);
          CFG_HY:    hy_q    <= $signed(cfg_wdata_i[15:0]);
          CFG_ORG:   org_q   <= cfg_wdata_i;
          CFG_TRANS: trans_q <= cfg_wdata_i;
          default:   ;
        endcase
      end
      if (cmd_q.fin == FIN_PY) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      x_q <= in_x_i;
      y_q <= in_y_i;
    end
    prod_q <= a_op * b_op;
    term_q <= ACC_W'(t_op) <<< F;
    acc_q  <= acc_d;
    case (cmd_q.fin)
      FIN_SIN: sin_q <= rom_q;
      FIN_COS: cos_q <= rom_q;
      FIN_TMP: tmp_q <= AW'(prod_q);
      FIN_COEF: begin
        case (cmd_q.dst)
          2'd0:    ca_q <= sat32(rnd16);
          2'd1:    cb_q <= sat32(rnd16);
          2'd2:    cd_q <= sat32(rnd16);
          default: ce_q <= sat32(rnd16);
        endcase
      end
      FIN_OFF: begin
        if (cmd_q.dst == 2'd0) oc_q <= sat32(rndf);
        else of_q <= sat32(rndf);
      end
      FIN_PX: begin
        rx_q   <= $signed(satv[23:0]);
        satx_q <= satv[24];
      end
      FIN_PY: begin
        outx_q   <= rx_q;
        outy_q   <= $signed(satv[23:0]);
        outsat_q <= satx_q | satv[24];
      end
      default: ;
    endcase
  end

  assign status_o.out_busy = out_valid_q;
  assign status_o.cfg_hit  = hit;
  assign out_valid_o       = out_valid_q;
  assign out_x_o           = outx_q;
  assign out_y_o           = outy_q;
  assign out_sat_o         = outsat_q;

endmodule

### hdl/apt_controller.sv
module apt_controller
  import apt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output logic       in_load_o,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       stale_q, stale_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 5'd0;
      stale_q <= 1'b1;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      stale_q <= stale_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    stale_d = stale_q | status_i.cfg_hit;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          step_d  = 5'd0;
          state_d = stale_q ? ST_REBUILD : ST_POINT;
        end
      end
      ST_REBUILD: begin
        if (step_q == REBUILD_LAST) begin
          step_d  = 5'd0;
          state_d = ST_POINT;
          stale_d = status_i.cfg_hit;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_POINT: begin
        if (step_q[2:0] == POINT_LAST) begin
          if (!status_i.out_busy) begin
            step_d  = 5'd0;
            state_d = ST_IDLE;
          end
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NOP;
    case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_REBUILD: cmd_o = rebuild_cmd(step_q);
      ST_POINT: begin
        if (!(step_q[2:0] == POINT_LAST && status_i.out_busy)) begin
          cmd_o = point_cmd(step_q[2:0]);
        end
      end
      default: cmd_o = CMD_NOP;
    endcase
    in_load_o = in_ready_o & in_valid_i;
  end

endmodule

### hdl/affine_point_transform_2d.sv
// Points go one at a time through the shared multiply-accumulate unit, which takes
// three accumulate steps per axis and rounds each axis in a step of its own; a word is
// accepted once the last point's final step issues; that step waits while a result is held.
// A configuration write marks the matrix stale, and only the next point rebuilds it.
// Reset: asynchronous active low; configuration registers return to identity, matrix marked stale.
`include "affine_point_transform_2d_macros.svh"

module affine_point_transform_2d
  import apt_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COEF_FRAC_BITS   = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // in_x[23:0], in_y[47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_x[23:0], out_y[47:24]
  output logic [0:0]  m_axis_tuser    // saturated[0]
);

  cmd_t               cmd;
  dp_status_t         status;
  logic               in_load;
  logic signed [23:0] out_x, out_y;
  logic               out_sat;

  apt_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .status_i  (status),
    .in_ready_o(s_axis_tready),
    .in_load_o (in_load),
    .cmd_o     (cmd)
  );

  apt_datapath #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_load_i  (in_load),
    .in_x_i     ($signed(s_axis_tdata[23:0])),
    .in_y_i     ($signed(s_axis_tdata[47:24])),
    .cmd_i      (cmd),
    .out_ready_i(m_axis_tready),
    .status_o   (status),
    .out_valid_o(m_axis_tvalid),
    .out_x_o    (out_x),
    .out_y_o    (out_y),
    .out_sat_o  (out_sat)
  );

  assign m_axis_tdata = {out_y, out_x};
  assign m_axis_tuser = out_sat;

  `APT_ASSERT_NOW(a_no_result_overwrite, cmd.fin == FIN_PY, !status.out_busy)
  `APT_ASSERT_NEXT(a_one_word_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `APT_ASSERT_NOW(a_load_only_when_ready, in_load, s_axis_tready && cmd.fin == FIN_NONE)

endmodule

### test/affine_point_transform_2d_test.sv
`timescale 1ns / 1ps

module affine_point_transform_2d_test;
  import apt_pkg::*;

  localparam int TBL_DEPTH = 1024;
  localparam int FRAC = 14;
  localparam longint ONE = longint'(1) << FRAC;
  localparam logic [2:0] CFG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic        sat;
  } point_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  affine_point_transform_2d dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // transform state mirrored from the configuration writes
  logic [15:0]        rot_angle;
  logic signed [15:0] scl_x, scl_y, shr_x, shr_y;
  logic [47:0]        org_xy, trn_xy;
  longint             coef_a, coef_b, coef_d, coef_e, off_c, off_f;
  bit                 matrix_dirty;

  point_res_t expected_points[$];
  int errors = 0;
  int points_sent = 0;
  int points_seen = 0;
  int saturated_seen = 0;
  int reg_writes = 0;
  int cycles = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_sink = 1'b0;

  function automatic longint round_q(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function automatic longint quarter_sin(longint unsigned k);
    longint unsigned xq, x2, term;
    longint acc;
    if (k >= TBL_DEPTH) return ONE;
    xq = (k * PI_Q30) / (2 * TBL_DEPTH);
    x2 = (xq * xq) >> 30;
    term = xq;
    acc = longint'(xq);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    if (acc > ONE) acc = ONE;
    return acc;
  endfunction

  function automatic longint sin_of(logic [15:0] ang);
    longint unsigned idx;
    longint v;
    idx = (longint'(ang[13:0]) * TBL_DEPTH) >> 14;
    v = ang[14] ? quarter_sin(TBL_DEPTH - idx) : quarter_sin(idx);
    return ang[15] ? -v : v;
  endfunction

  function automatic void rebuild_matrix();
    longint s, c, sx, sy, hx, hy, ox, oy, tx, ty;
    s = sin_of(rot_angle);
    c = sin_of(rot_angle + 16'h4000);
    sx = scl_x;
    sy = scl_y;
    hx = shr_x;
    hy = shr_y;
    ox = longint'($signed(org_xy[23:0]));
    oy = longint'($signed(org_xy[47:24]));
    tx = longint'($signed(trn_xy[23:0]));
    ty = longint'($signed(trn_xy[47:24]));
    coef_a = clamp32(round_q(c * sx * 256 - s * hy * sy, 16));
    coef_b = clamp32(round_q(-s * sy * 256 + c * hx * sx, 16));
    coef_d = clamp32(round_q(s * sx * 256 + c * hy * sy, 16));
    coef_e = clamp32(round_q(c * sy * 256 + s * hx * sx, 16));
    off_c = clamp32(round_q(-ox * (coef_a - ONE) - oy * coef_b + tx * ONE, FRAC));
    off_f = clamp32(round_q(-ox * coef_d - oy * (coef_e - ONE) + ty * ONE, FRAC));
    matrix_dirty = 1'b0;
  endfunction

  function automatic point_res_t transform_point(logic signed [23:0] x, logic signed [23:0] y);
    point_res_t r;
    longint rx, ry;
    if (matrix_dirty) rebuild_matrix();
    rx = round_q(coef_a * x + coef_b * y + off_c * ONE, FRAC);
    ry = round_q(coef_d * x + coef_e * y + off_f * ONE, FRAC);
    r.sat = 1'b0;
    if (rx < -8388608) begin rx = -8388608; r.sat = 1'b1; end
    if (rx > 8388607) begin rx = 8388607; r.sat = 1'b1; end
    if (ry < -8388608) begin ry = -8388608; r.sat = 1'b1; end
    if (ry > 8388607) begin ry = 8388607; r.sat = 1'b1; end
    r.x = rx[23:0];
    r.y = ry[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[affine_point_transform_2d] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    point_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      points_seen++;
      if (m_axis_tuser[0]) saturated_seen++;
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[23:0], 24'h0);
      end else begin
        want = expected_points.pop_front();
        if (m_axis_tdata[23:0] !== want.x) report_mismatch("out_x", m_axis_tdata[23:0], want.x);
        if (m_axis_tdata[47:24] !== want.y) report_mismatch("out_y", m_axis_tdata[47:24], want.y);
        if (m_axis_tuser[0] !== want.sat) begin
          report_mismatch("saturated", {23'd0, m_axis_tuser}, {23'd0, want.sat});
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_points.push_back(transform_point(x, y));
    points_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      CFG_ROT:   rot_angle = val[15:0];
      CFG_SX:    scl_x = val[15:0];
      CFG_SY:    scl_y = val[15:0];
      CFG_HX:    shr_x = val[15:0];
      CFG_HY:    shr_y = val[15:0];
      CFG_ORG:   org_xy = val;
      CFG_TRANS: trn_xy = val;
      default:   return;
    endcase
    matrix_dirty = 1'b1;
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'hFFFFFF;
          default: return 24'h000000;
        endcase
      end
      default: return 24'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [15:0] rand_factor();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      3: return 16'h0000;
      default: return 16'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic logic [47:0] rand_pair();
    if ($urandom_range(0, 3) == 0) return 48'({$urandom, $urandom});
    return {rand_coord(), rand_coord()};
  endfunction

  task automatic test_directed();
    send_point(24'h000000, 24'h000000);
    send_point(24'h7FFFFF, 24'h800000);
    send_point(24'h800000, 24'h7FFFFF);
    send_point(24'hFFFFFF, 24'h000001);
    wait_idle();
    write_reg(CFG_ROT, 48'h4000);
    send_point(24'h000100, 24'h000200);
    wait_idle();
    write_reg(CFG_ROT, 48'hFFFF_0000_FFFF);
    send_point(24'h7FFFFF, 24'h7FFFFF);
    wait_idle();
    write_reg(CFG_ROT, 48'h2000);
    write_reg(CFG_SX, 48'h7FFF);
    write_reg(CFG_SY, 48'h8000);
    send_point(24'h000100, 24'hFFFF00);
    send_point(24'h7FFFFF, 24'h800000);
    wait_idle();
    write_reg(CFG_HX, 48'h7FFF);
    write_reg(CFG_HY, 48'h8000);
    send_point(24'h000001, 24'h000001);
    wait_idle();
    write_reg(CFG_ROT, 48'h8000);
    write_reg(CFG_SX, 48'h0100);
    write_reg(CFG_SY, 48'h0080);
    write_reg(CFG_HX, 48'h0040);
    write_reg(CFG_HY, 48'hFFC0);
    write_reg(CFG_ORG, {24'h7FFFFF, 24'h800000});
    write_reg(CFG_TRANS, {24'h800000, 24'h7FFFFF});
    send_point(24'h001000, 24'h002000);
    wait_idle();
    write_reg(CFG_ORG, {24'h000A00, 24'hFFF600});
    write_reg(CFG_TRANS, {24'h000500, 24'h000300});
    write_reg(CFG_ROT, 48'hC000);
    send_point(24'h000A00, 24'hFFF600);
    send_point(24'h001234, 24'hFEDCBA);
    wait_idle();
    write_reg(CFG_SPARE, 48'hFFFF_FFFF_FFFF);
    send_point(24'h000300, 24'h000400);
    wait_idle();
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      src_idle_on = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 1)) write_reg(CFG_ROT, 48'({$urandom, $urandom}));
      if ($urandom_range(0, 1)) write_reg(CFG_SX, {32'($urandom), rand_factor()});
      if ($urandom_range(0, 1)) write_reg(CFG_SY, {32'h0, rand_factor()});
      if ($urandom_range(0, 2) == 0) write_reg(CFG_HX, {32'h0, rand_factor()});
      if ($urandom_range(0, 2) == 0) write_reg(CFG_HY, {32'h0, rand_factor()});
      if ($urandom_range(0, 2) == 0) write_reg(CFG_ORG, rand_pair());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_TRANS, rand_pair());
      if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, 48'({$urandom, $urandom}));
      for (int i = 0; i < per_phase; i++) send_point(rand_coord(), rand_coord());
      wait_idle();
    end
  endtask

  task automatic test_output_stall();
    hold_sink = 1'b1;
    for (int i = 0; i < 40; i++) send_point(rand_coord(), rand_coord());
    wait_idle();
  endtask

  task automatic test_full_rate();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    write_reg(CFG_ROT, 48'h1555);
    write_reg(CFG_SX, 48'h0180);
    for (int i = 0; i < 150; i++) send_point(rand_coord(), rand_coord());
    wait_idle();
  endtask

  initial begin
    rot_angle = '0;
    scl_x = 16'sd256;
    scl_y = 16'sd256;
    shr_x = '0;
    shr_y = '0;
    org_xy = '0;
    trn_xy = '0;
    matrix_dirty = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings(28, 55);
    test_output_stall();
    test_random_settings(4, 40);
    test_full_rate();
    $display("covered %0d points (%0d saturated) over %0d register writes,",
             points_sent, saturated_seen, reg_writes);
    $display("with rotation, scale, shear, pivot and offset extremes and output stalls");
    if (errors == 0 && points_seen == points_sent) begin
      $display("[affine_point_transform_2d] OK");
    end else begin
      $display("[affine_point_transform_2d] ERROR");
    end
    $finish;
  end

endmodule
